// File: rtl/core/mdag_pkg.sv
// Shared widths, codes, state type and control bundle of the array address generator.
`timescale 1ns / 1ps

package mdag_pkg;

    // Default number of table entries (dimensions)
    localparam int DEF_MAX_DIMS = 16;

    // Field widths
    localparam int DIM_W      = 5;
    localparam int BND_W      = 16;
    localparam int EXT_W      = 18;   // upper - lower + 1 spans -65534..65536
    localparam int DIFF_W     = 17;
    localparam int BASE_W     = 32;
    localparam int ESIZE_W    = 16;
    localparam int ADDR_W_OUT = 32;

    // Accumulator is exact while inside +-2^40, so 42 signed bits carry it
    localparam int ACC_W  = 42;
    localparam int HALF_W = 21;
    localparam int OPA_W  = HALF_W + 1;
    localparam int OPB_W  = EXT_W;
    localparam int PROD_W = OPA_W + OPB_W;
    localparam int SUM_W  = 61;

    localparam logic signed [SUM_W-1:0] BIG_LIMIT = 61'sd1099511627776;

    // Stream and configuration port widths
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_SIZE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIMENSION_COUNT = 2'd2;

    // Item modes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_INDEX = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MAC_HI,
        S_SCALE_LO,
        S_SCALE_HI,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic clear_acc;
        logic load_opnd;
        logic load_prod;
        logic opa_hi;
        logic opb_esize;
        logic update_acc;
        logic load_scaled;
    } t_dp_ctrl;

endpackage

// File: rtl/core/mdag_datapath.sv
// Accumulator, shared two-pass multiplier and address scaling of the address generator.
`timescale 1ns / 1ps

module mdag_datapath import mdag_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_dp_ctrl                     i_ctrl,
    input  logic signed [BND_W-1:0]      i_index,
    input  logic signed [BND_W-1:0]      i_lower,
    input  logic signed [EXT_W-1:0]      i_extent,
    input  logic        [ESIZE_W-1:0]    i_element_size,
    input  logic signed [BASE_W-1:0]     i_base_address,
    output logic        [ADDR_W_OUT-1:0] o_address,
    output logic                         o_overflow
);

    logic        [ACC_W-1:0]  r_acc;
    logic                     r_large;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [DIFF_W-1:0] r_diff;
    logic signed [EXT_W-1:0]  r_ext;
    logic        [SUM_W-1:0]  r_scaled;

    logic signed [OPA_W-1:0]  w_opa;
    logic signed [OPB_W-1:0]  w_opb;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [DIFF_W-1:0] w_diff;
    logic        [SUM_W-1:0]  w_hi_ext;
    logic        [SUM_W-1:0]  w_hi_shift;
    logic        [SUM_W-1:0]  w_lo_ext;
    logic        [SUM_W-1:0]  w_diff_ext;
    logic        [SUM_W-1:0]  w_sum;
    logic        [SUM_W-1:0]  w_exact;
    logic                     w_big;
    logic                     w_ext_zero;
    logic                     w_fits;

    // Pick the accumulator half and the second factor for the shared multiplier
    always_comb begin
        if (i_ctrl.opa_hi) begin
            w_opa = {r_acc[ACC_W-1], r_acc[ACC_W-1:HALF_W]};
        end else begin
            w_opa = {1'b0, r_acc[HALF_W-1:0]};
        end
        if (i_ctrl.opb_esize) begin
            w_opb = {{(OPB_W-ESIZE_W){1'b0}}, i_element_size};
        end else if (i_ctrl.load_opnd) begin
            w_opb = i_extent;
        end else begin
            w_opb = r_ext;
        end
    end

    assign w_prod = w_opa * w_opb;
    assign w_diff = {i_index[BND_W-1], i_index} - {i_lower[BND_W-1], i_lower};

    // Combine the upper partial product with the stored lower one
    assign w_hi_ext   = {{(SUM_W-PROD_W){w_prod[PROD_W-1]}}, w_prod};
    assign w_hi_shift = {w_hi_ext[SUM_W-1-HALF_W:0], {HALF_W{1'b0}}};
    assign w_lo_ext   = {{(SUM_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign w_diff_ext = {{(SUM_W-DIFF_W){r_diff[DIFF_W-1]}}, r_diff};
    assign w_sum      = w_hi_shift + w_lo_ext + w_diff_ext;

    assign w_big      = ($signed(w_sum) > BIG_LIMIT) || ($signed(w_sum) < -BIG_LIMIT);
    assign w_ext_zero = (r_ext == '0);

    // Final address and range check
    assign w_exact = r_scaled + {{(SUM_W-BASE_W){i_base_address[BASE_W-1]}}, i_base_address};
    assign w_fits  = (&w_exact[SUM_W-1:ADDR_W_OUT-1]) || !(|w_exact[SUM_W-1:ADDR_W_OUT-1]);

    assign o_address  = w_exact[ADDR_W_OUT-1:0];
    assign o_overflow = (i_element_size != '0) && (r_large || !w_fits);

    // Accumulator and large flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_large <= 1'b0;
        end else if (i_ctrl.clear_acc) begin
            r_acc   <= '0;
            r_large <= 1'b0;
        end else if (i_ctrl.update_acc) begin
            r_acc   <= w_sum[ACC_W-1:0];
            r_large <= (r_large && !w_ext_zero) || w_big;
        end
    end

    // Operands and partial products
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_opnd) begin
            r_diff <= w_diff;
            r_ext  <= i_extent;
        end
        if (i_ctrl.load_prod) begin
            r_prod <= w_prod;
        end
        if (i_ctrl.load_scaled) begin
            r_scaled <= w_hi_shift + w_lo_ext;
        end
    end

    // A restart leaves an exact zero behind
    a_clear_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.clear_acc |=> (r_acc == '0) && !r_large)
        else $error("accumulator not cleared on restart");

    // A zero extent makes the accumulator exact again
    a_zero_ext: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.update_acc && w_ext_zero |=> !r_large)
        else $error("large flag kept across a zero extent");

endmodule

// File: rtl/core/multidim_array_address_generator_top.sv
// Top level of the row-major multi-dimensional array address generator.
`timescale 1ns / 1ps

// Bounds items (tuser 0) write one dimension's lower bound and extent into the
// bounds table, and the next item is taken in the cycle after. Index items
// (tuser 1) read the table, then run the Horner step through one shared 22x18
// multiplier in two passes; for the last dimension, the scale by element size
// takes two more passes of the same multiplier and the base add follows in the
// emit step. The address lands in an output register; while an earlier result
// still waits there for i_m_tready, the block holds in its emit step and takes
// no new item. Index items whose dimension is out of range are dropped with
// no result. The bounds table has no reset: load every dimension before
// indexing it.
module multidim_array_address_generator_top import mdag_pkg::*; #(
    parameter int MAX_DIMS = DEF_MAX_DIMS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input items
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,   // dim[4:0], lower_bound[20:5],
                                               // upper_bound[36:21], index_value[52:37]
    input  logic                  i_s_tuser,   // mode
    // Result items
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_TDATA_W-1:0]  o_m_tdata,   // address[31:0], overflow[32]
    // Register writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int ADDR_W       = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int SLOT_W       = (ADDR_W > DIM_W) ? ADDR_W : DIM_W;
    localparam int DIM_CODE_MAX = (1 << DIM_W) - 1;
    localparam int DIM_LIM_I    = (MAX_DIMS > DIM_CODE_MAX) ? DIM_CODE_MAX : MAX_DIMS;
    localparam logic [DIM_W-1:0] DIM_LIM = DIM_W'(DIM_LIM_I);
    localparam int MEM_W        = EXT_W + BND_W;

    t_state r_state;
    t_state n_state;
    t_dp_ctrl w_ctrl;

    logic signed [BASE_W-1:0]  r_cfg_base;
    logic        [ESIZE_W-1:0] r_cfg_esize;
    logic        [DIM_W-1:0]   r_dim_count;

    logic                      r_last;
    logic signed [BND_W-1:0]   r_index;
    logic        [MEM_W-1:0]   r_mem_q;
    logic                      r_m_tvalid;
    logic [M_TDATA_W-1:0]      r_m_tdata;

    logic [MEM_W-1:0] mem [MAX_DIMS];

    logic                     w_mode;
    logic        [DIM_W-1:0]  w_dim;
    logic signed [BND_W-1:0]  w_lower;
    logic signed [BND_W-1:0]  w_upper;
    logic signed [BND_W-1:0]  w_index;
    logic signed [EXT_W-1:0]  w_extent;
    logic        [SLOT_W-1:0] w_slot;
    logic        [ADDR_W-1:0] w_addr;
    logic        [DIM_W-1:0]  w_eff_dims;
    logic                     w_s_acc;
    logic                     w_load_ok;
    logic                     w_index_ok;
    logic                     w_start;
    logic                     w_mem_we;
    logic                     w_mem_re;
    logic                     w_out_free;
    logic [ADDR_W_OUT-1:0]    w_address;
    logic                     w_overflow;

    // Unpack the input item
    assign w_mode  = i_s_tuser;
    assign w_dim   = i_s_tdata[DIM_W-1:0];
    assign w_lower = i_s_tdata[DIM_W +: BND_W];
    assign w_upper = i_s_tdata[DIM_W+BND_W +: BND_W];
    assign w_index = i_s_tdata[DIM_W+2*BND_W +: BND_W];

    assign w_extent = {{(EXT_W-BND_W){w_upper[BND_W-1]}}, w_upper}
                    - {{(EXT_W-BND_W){w_lower[BND_W-1]}}, w_lower} + EXT_W'(1);

    // Clamp the dimension count into 1..DIM_LIM (MAX_DIMS, but at most 31)
    always_comb begin
        if (r_dim_count == '0) begin
            w_eff_dims = DIM_W'(1);
        end else if (r_dim_count > DIM_LIM) begin
            w_eff_dims = DIM_LIM;
        end else begin
            w_eff_dims = r_dim_count;
        end
    end

    assign w_slot     = SLOT_W'(w_dim) - SLOT_W'(1);
    assign w_addr     = w_slot[ADDR_W-1:0];
    assign w_load_ok  = (w_dim != '0) && (w_dim <= DIM_LIM);
    assign w_index_ok = (w_dim != '0) && (w_dim <= w_eff_dims);

    assign o_s_tready = (r_state == S_IDLE);
    assign w_s_acc    = i_s_tvalid && o_s_tready;
    assign w_start    = w_s_acc && (w_mode == MODE_INDEX) && w_index_ok;
    assign w_mem_we   = w_s_acc && (w_mode == MODE_LOAD) && w_load_ok;
    assign w_mem_re   = w_start;
    assign w_out_free = !r_m_tvalid || i_m_tready;

    // Bounds table: extent above lower bound in each entry
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[w_addr] <= {w_extent, w_lower};
        end
        if (w_mem_re) begin
            r_mem_q <= mem[w_addr];
        end
    end

    // Register writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_base  <= '0;
            r_cfg_esize <= ESIZE_W'(1);
            r_dim_count <= DIM_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_BASE_ADDRESS:    r_cfg_base  <= i_cfg_data[BASE_W-1:0];
                REG_ELEMENT_SIZE:    r_cfg_esize <= i_cfg_data[ESIZE_W-1:0];
                REG_DIMENSION_COUNT: r_dim_count <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer: next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_start) begin
                    n_state = S_READ;
                end
            end
            S_READ:     n_state = S_MAC_HI;
            S_MAC_HI:   n_state = r_last ? S_SCALE_LO : S_IDLE;
            S_SCALE_LO: n_state = S_SCALE_HI;
            S_SCALE_HI: n_state = S_EMIT;
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // Sequencer: datapath controls
    always_comb begin
        w_ctrl = '0;
        unique case (r_state)
            S_IDLE: begin
                w_ctrl.clear_acc = w_start && (w_dim == DIM_W'(1));
            end
            S_READ: begin
                w_ctrl.load_opnd = 1'b1;
                w_ctrl.load_prod = 1'b1;
            end
            S_MAC_HI: begin
                w_ctrl.opa_hi     = 1'b1;
                w_ctrl.update_acc = 1'b1;
            end
            S_SCALE_LO: begin
                w_ctrl.opb_esize = 1'b1;
                w_ctrl.load_prod = 1'b1;
            end
            S_SCALE_HI: begin
                w_ctrl.opa_hi      = 1'b1;
                w_ctrl.opb_esize   = 1'b1;
                w_ctrl.load_scaled = 1'b1;
            end
            S_EMIT:  ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_start) begin
                r_last <= (w_dim == w_eff_dims);
            end
        end
    end

    // Hold the subscript for the table read
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_index <= w_index;
        end
    end

    mdag_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (w_ctrl),
        .i_index        (r_index),
        .i_lower        (r_mem_q[BND_W-1:0]),
        .i_extent       (r_mem_q[MEM_W-1:BND_W]),
        .i_element_size (r_cfg_esize),
        .i_base_address (r_cfg_base),
        .o_address      (w_address),
        .o_overflow     (w_overflow)
    );

    // Output register: load when the slot is free, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if ((r_state == S_EMIT) && w_out_free) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_EMIT) && w_out_free) begin
            r_m_tdata <= M_TDATA_W'({w_overflow, w_address});
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

    // A stalled result keeps the next one waiting in the emit step
    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) && !w_out_free |=> (r_state == S_EMIT) && r_m_tvalid)
        else $error("result overwritten while stalled");

    // A result appears only out of the emit step
    a_emit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_tvalid) |-> $past(r_state) == S_EMIT)
        else $error("result raised outside the emit step");

    // Table data is used only in the cycle after its read
    a_read_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> $past(w_mem_re))
        else $error("table data used without a read");

    // Scaling runs only for the last dimension
    a_scale_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCALE_LO) |-> r_last)
        else $error("scale step for an inner dimension");

endmodule
